### src/ps2fifo_pkg.sv
package ps2fifo_pkg;

	localparam int FIFO_DEPTH = 256;
	localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int MAP_SIZE   = 64;

	localparam logic [6:0] LSHIFT_KEY = 7'h2A;
	localparam logic [6:0] RSHIFT_KEY = 7'h36;

	typedef enum logic [2:0] {
		ST_READ_OK    = 3'd0,
		ST_READ_EMPTY = 3'd1,
		ST_QUEUED     = 3'd2,
		ST_NO_CHAR    = 3'd3,
		ST_DROPPED    = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE = 2'b01,
		FSM_READ = 2'b10
	} fsm_t;

	// Decoder verdict for one scan byte
	typedef struct packed {
		logic       shift_make;
		logic       shift_break;
		logic [6:0] ch;
	} dec_t;

	// US layout, scan code set 1; codes past the space bar map to zero
	localparam logic [6:0] PLAIN_MAP [MAP_SIZE] = '{
		7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
		7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
		7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
		7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
		7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
		7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
		7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
		7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
	};

	localparam logic [6:0] UPPER_MAP [MAP_SIZE] = '{
		7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
		7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
		7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
		7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
		7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
		7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
		7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
		7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
	};

	function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] idx);
		if (idx == PTR_W'(FIFO_DEPTH - 1)) begin
			return '0;
		end
		return PTR_W'(idx + PTR_W'(1));
	endfunction

endpackage

### src/ps2fifo_req_if.sv
interface ps2fifo_req_if;
	logic       valid;
	logic       ready;
	logic       req_type;
	logic [7:0] scan_byte;

	modport source (output valid, req_type, scan_byte, input ready);
	modport sink (input valid, req_type, scan_byte, output ready);
endinterface

### src/ps2fifo_rsp_if.sv
interface ps2fifo_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [6:0] char_code;

	modport source (output valid, status, char_code, input ready);
	modport sink (input valid, status, char_code, output ready);
endinterface

### src/ps2fifo_decode.sv
module ps2fifo_decode import ps2fifo_pkg::*; (
	input  logic [7:0] scan_byte,
	input  logic       shift_held,
	output dec_t       dec
);

	logic [6:0] key;
	logic       is_shift;
	logic [6:0] mapped;

	assign key      = scan_byte[6:0];
	assign is_shift = (key == LSHIFT_KEY) || (key == RSHIFT_KEY);

	// keys past the table read as unmapped
	always_comb begin
		if (key[6]) begin
			mapped = '0;
		end else if (shift_held) begin
			mapped = UPPER_MAP[key[5:0]];
		end else begin
			mapped = PLAIN_MAP[key[5:0]];
		end
	end

	assign dec.shift_make  = !scan_byte[7] && is_shift;
	assign dec.shift_break = scan_byte[7] && is_shift;
	assign dec.ch          = (scan_byte[7] || is_shift) ? 7'd0 : mapped;

endmodule

### src/ps2_scancode_to_ascii_fifo_core.sv
// A scan byte or an empty read is registered straight into the result register;
// a read that pops a character registers the store data first, then the result.
// Throughput: one scan byte per cycle while the result slot is free or draining; a
// popping read stalls requests until the single read port's registered data loads.
// Reset: pointers, shift flag, control state and result valid clear at once;
// the character store is not cleared and holds nothing readable until written.
module ps2_scancode_to_ascii_fifo_core import ps2fifo_pkg::*; (
	input logic           clk,
	input logic           arst_n,
	ps2fifo_req_if.sink   req_ch,
	ps2fifo_rsp_if.source rsp_ch
);

	// Character store: one write port, one registered read port
	logic [6:0] char_mem [FIFO_DEPTH];
	logic [6:0] rd_data_q;

	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic             shift_q;
	fsm_t             state_q;

	logic       out_valid_q;
	status_t    out_status_q;
	logic [6:0] out_char_q;

	dec_t             dec;
	logic             out_free;
	logic             accept;
	logic             fifo_empty;
	logic             fifo_full;
	logic [PTR_W-1:0] wr_ptr_nxt;

	logic       load_out;
	status_t    load_status;
	logic [6:0] load_char;
	logic       mem_we;
	logic       mem_re;
	logic       pop;
	logic       shift_set;
	logic       shift_clr;
	fsm_t       state_d;

	ps2fifo_decode u_decode (
		.scan_byte  (req_ch.scan_byte),
		.shift_held (shift_q),
		.dec        (dec)
	);

	// Take a new request only from idle, with the result slot free or draining
	assign out_free     = !out_valid_q || rsp_ch.ready;
	assign req_ch.ready = (state_q == FSM_IDLE) && out_free;
	assign accept       = req_ch.valid && req_ch.ready;

	assign wr_ptr_nxt = wrap_next(wr_ptr_q);
	assign fifo_empty = (wr_ptr_q == rd_ptr_q);
	assign fifo_full  = (wr_ptr_nxt == rd_ptr_q);

	always_comb begin
		load_out    = 1'b0;
		load_status = ST_NO_CHAR;
		load_char   = '0;
		mem_we      = 1'b0;
		mem_re      = 1'b0;
		pop         = 1'b0;
		shift_set   = 1'b0;
		shift_clr   = 1'b0;
		state_d     = state_q;
		case (state_q)
			FSM_IDLE: begin
				if (accept) begin
					if (req_ch.req_type) begin
						if (fifo_empty) begin
							load_out    = 1'b1;
							load_status = ST_READ_EMPTY;
						end else begin
							// issue the store read, finish next cycle
							mem_re  = 1'b1;
							state_d = FSM_READ;
						end
					end else begin
						load_out = 1'b1;
						if (dec.shift_break) begin
							shift_clr = 1'b1;
						end else if (dec.shift_make) begin
							shift_set = 1'b1;
						end else if (dec.ch == 7'd0) begin
							load_status = ST_NO_CHAR;
						end else if (fifo_full) begin
							load_status = ST_DROPPED;
						end else begin
							mem_we      = 1'b1;
							load_status = ST_QUEUED;
							load_char   = dec.ch;
						end
					end
				end
			end
			FSM_READ: begin
				// result slot was freed when the read was accepted
				load_out    = 1'b1;
				load_status = ST_READ_OK;
				load_char   = rd_data_q;
				pop         = 1'b1;
				state_d     = FSM_IDLE;
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			char_mem[wr_ptr_q] <= dec.ch;
		end
		if (mem_re) begin
			rd_data_q <= char_mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= FSM_IDLE;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			shift_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (mem_we) begin
				wr_ptr_q <= wr_ptr_nxt;
			end
			if (pop) begin
				rd_ptr_q <= wrap_next(rd_ptr_q);
			end
			if (shift_set) begin
				shift_q <= 1'b1;
			end else if (shift_clr) begin
				shift_q <= 1'b0;
			end
		end
	end

	// Result register: hold until transfer, then drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_status_q <= load_status;
			out_char_q   <= load_char;
		end
	end

	assign rsp_ch.valid     = out_valid_q;
	assign rsp_ch.status    = out_status_q;
	assign rsp_ch.char_code = out_char_q;

endmodule
